FILE: hdl/sbqz_pkg.sv
// shared constants and types for the segmented biquad with zero-initial-condition segments
// no dependencies; imported by sbqz_fb and segmented_biquad_zero_init
`default_nettype none

package sbqz_pkg;

    // segment length in samples, legal range 3 .. 64
    localparam int SEG_LEN   = 8;
    localparam int SEG_POS_W = $clog2(SEG_LEN);

    // field widths
    localparam int X_W    = 16;             // input sample
    localparam int COEF_W = 16;             // Q2.14 coefficient
    localparam int Y_W    = 24;             // saturated output
    localparam int FRAC_W = 14;             // coefficient fraction bits
    localparam int V_W    = X_W + 4;        // feed-forward sum
    localparam int PFF_W  = X_W + COEF_W;   // feed-forward product
    localparam int PFB_W  = Y_W + COEF_W;   // feedback product
    localparam int WIDE_W = PFB_W - FRAC_W + 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A2 = 2'd3;

    // saturation bounds
    localparam logic signed [WIDE_W-1:0] Y_MAX = WIDE_W'(signed'((1 << (Y_W - 1)) - 1));
    localparam logic signed [WIDE_W-1:0] Y_MIN = WIDE_W'(signed'(-(1 << (Y_W - 1))));

    // feed-forward stage result handed to the recursion
    typedef struct packed {
        logic signed [V_W-1:0] v;
        logic                  first;
        logic                  last;
    } t_s1;

endpackage

`default_nettype wire

FILE: hdl/sbqz_fb.sv
// second-order recursion with per-segment restart and 24-bit saturation
// depends on sbqz_pkg (widths, bounds, t_s1)
`default_nettype none

module sbqz_fb
    import sbqz_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,       // stage advances this cycle
    input  wire t_s1                      i_s1,
    input  wire logic signed [COEF_W-1:0] i_a1,
    input  wire logic signed [COEF_W-1:0] i_a2,
    output logic signed [Y_W-1:0]         o_w
);

    logic signed [Y_W-1:0]    r_w1, r_w2;
    logic signed [Y_W-1:0]    w1_eff, w2_eff;
    logic signed [PFB_W-1:0]  prod1, prod2;
    logic signed [WIDE_W-1:0] wide;

    // output history counts as zero at segment start
    assign w1_eff = i_s1.first ? '0 : r_w1;
    assign w2_eff = i_s1.first ? '0 : r_w2;

    assign prod1 = i_a1 * w1_eff;
    assign prod2 = i_a2 * w2_eff;

    // floor shift by the fraction width is a plain bit slice, sign-extended
    assign wide = WIDE_W'(i_s1.v)
                + WIDE_W'($signed(prod1[PFB_W-1:FRAC_W]))
                + WIDE_W'($signed(prod2[PFB_W-1:FRAC_W]));

    always_comb begin
        priority if (wide > Y_MAX) begin
            o_w = Y_MAX[Y_W-1:0];
        end else if (wide < Y_MIN) begin
            o_w = Y_MIN[Y_W-1:0];
        end else begin
            o_w = wide[Y_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w1 <= '0;
            r_w2 <= '0;
        end else if (i_en) begin
            r_w1 <= o_w;
            r_w2 <= w1_eff;
        end
    end

    a_restart_clears_w2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_s1.first) |=> (r_w2 == '0))
        else $error("w2 not cleared at segment start");

    a_history_shifts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !i_s1.first) |=> (r_w2 == $past(r_w1)))
        else $error("output history did not shift");

    a_w1_is_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |=> (r_w1 == $past(o_w)))
        else $error("w1 does not hold last result");

endmodule

`default_nettype wire

FILE: hdl/segmented_biquad_zero_init.sv
// top level: segmented second-order recursive filter, zero-initial-condition part
// depends on sbqz_pkg and sbqz_fb
`default_nettype none

// Streams one 16-bit sample per word in, one 24-bit saturated result per word out,
// in order. Each sample passes the feed-forward section v = x + b1*x1 + b2*x2 (input
// history runs on across segments), then the recursion w = v + a1*w1 + a2*w2 whose
// output history is taken as zero at the first sample of every segment of SEG_LEN
// samples. Products of Q2.14 coefficients are floor-shifted by 14 bits. tlast marks
// the last sample of each segment. Throughput is one sample per clock unless the output stalls; a word
// passes the feed-forward register, then the output register. The clock period is set by
// the feedback path in sbqz_fb: two 16x24 multiplies, a three-way add and the saturation,
// closed through the w1/w2 history. Coefficients must be written through the plain
// write port only while the stream is idle; the block does not enforce this. All
// coefficients reset to zero, which makes the block a pass-through.
module segmented_biquad_zero_init
    import sbqz_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [COEF_W-1:0]     i_cfg_wr_data,
    // input stream
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [15:0]           i_s_tdata,   // [15:0] sample_in
    // output stream
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [23:0]                o_m_tdata,   // [23:0] filtered_out
    output logic                       o_m_tlast    // segment_end
);

    // coefficient registers
    logic signed [COEF_W-1:0] r_b1, r_b2, r_a1, r_a2;

    // input history and segment counter
    logic signed [X_W-1:0]    r_x1, r_x2;
    logic [SEG_POS_W-1:0]     r_seg_pos, n_seg_pos;

    // feed-forward stage register
    logic                     r_s1_valid;
    t_s1                      r_s1, n_s1;

    // output register
    logic                     r_m_valid;
    logic signed [Y_W-1:0]    r_m_data;
    logic                     r_m_last;

    logic                     s_accept;
    logic                     out_adv;     // output register may load
    logic                     s1_adv;      // stage 1 word moves to output
    logic signed [X_W-1:0]    x_in;
    logic signed [PFF_W-1:0]  prod_b1, prod_b2;
    logic signed [Y_W-1:0]    w_res;
    logic                     is_last;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_B1:  r_b1 <= i_cfg_wr_data;
                REG_B2:  r_b2 <= i_cfg_wr_data;
                REG_A1:  r_a1 <= i_cfg_wr_data;
                REG_A2:  r_a2 <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    // output register frees when empty or being taken; stage 1 frees when empty
    // or moving forward, so input stalls only while both registers hold words
    // and the output word is not taken
    assign out_adv    = !r_m_valid || i_m_tready;
    assign s1_adv     = r_s1_valid && out_adv;
    assign o_s_tready = !r_s1_valid || out_adv;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // ---------------- feed-forward stage ----------------
    assign x_in    = i_s_tdata[X_W-1:0];
    assign prod_b1 = r_b1 * r_x1;
    assign prod_b2 = r_b2 * r_x2;
    assign is_last = (r_seg_pos >= SEG_POS_W'(SEG_LEN - 1));

    always_comb begin
        n_s1.v     = V_W'(x_in)
                   + V_W'($signed(prod_b1[PFF_W-1:FRAC_W]))
                   + V_W'($signed(prod_b2[PFF_W-1:FRAC_W]));
        n_s1.first = (r_seg_pos == '0);
        n_s1.last  = is_last;
        n_seg_pos  = is_last ? '0 : r_seg_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1       <= '0;
            r_x2       <= '0;
            r_seg_pos  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_x1      <= x_in;
                r_x2      <= r_x1;
                r_seg_pos <= n_seg_pos;
            end
            if (o_s_tready) begin
                r_s1_valid <= i_s_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1 <= n_s1;
        end
    end

    // ---------------- recursion ----------------
    sbqz_fb u_fb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s1_adv),
        .i_s1    (r_s1),
        .i_a1    (r_a1),
        .i_a2    (r_a2),
        .o_w     (w_res)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_adv) begin
            r_m_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_m_data <= w_res;
            r_m_last <= r_s1.last;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;

    // ---------------- checks ----------------
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg_pos <= SEG_POS_W'(SEG_LEN - 1))
        else $error("segment position out of range");

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.last) |-> (r_seg_pos == '0))
        else $error("counter did not wrap after last sample");

    a_mid_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1.last) |-> (r_seg_pos != '0))
        else $error("counter wrapped inside a segment");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_s_tready)
        else $error("input stalled with empty stage");

endmodule

`default_nettype wire
